### src/algs_pkg.sv
// Shared codes, field widths and default sizes for the adjacency-list graph store.
package algs_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_MAX_DEGREE   = 16;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;
    localparam int ACT_W      = 3;
    localparam int STAT_W     = 3;

    localparam logic [ACT_W-1:0] ACT_ADD_V  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_E  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIRST  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADV   = 3'd1;
    localparam logic [STAT_W-1:0] ST_LFULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOENT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_VFULL  = 3'd4;

endpackage

### src/algs_ram.sv
// Simple dual-port synchronous RAM with registered read.
module algs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/adjacency_list_graph_store_core.sv
// Adjacency-list graph store: per-vertex circular edge lists in RAM, one result per beat.
// Query edge scans the whole list of vertex a with one RAM read per entry; delete copies
// the last vertex's row into the freed slot (skipped when the last vertex goes), then
// sweeps every live vertex's list with one RAM read per stored entry to compact it.
// One beat is in flight at a time, so the next beat is taken once the result has loaded.
// Reset (rst_n low, asynchronous) empties the graph: counts and list lengths clear,
// key and edge RAM contents stay undefined until written.
module adjacency_list_graph_store_core #(
    parameter int MAX_VERTICES = algs_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = algs_pkg::DEF_MAX_DEGREE
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // vertex_a[3:0], vertex_b[7:4], edge_weight[23:8], vertex_key[31:24],
    // entry_position[35:32], zero fill [39:36]
    input  logic [algs_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[2:0]
    input  logic [algs_pkg::ACT_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // edge_found[0], neighbor_out[4:1], weight_out[20:5], key_out[28:21],
    // vertex_count[33:29], edge_count[42:34], zero fill [47:43]
    output logic [algs_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status[2:0]
    output logic [algs_pkg::STAT_W-1:0]      m_tuser
);

    import algs_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);              // vertex slot index
    localparam int DW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1; // list position
    localparam int LNW = $clog2(MAX_DEGREE + 1);            // list length
    localparam int LW  = $clog2(MAX_VERTICES + 1);          // live vertex count
    localparam int ED  = MAX_VERTICES * MAX_DEGREE;
    localparam int AW  = $clog2(ED);
    localparam int EW  = $clog2(ED + 1);                    // total edge count
    localparam int EWD = VW + 16;                           // {neighbor, weight}

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_QRD, S_RDE, S_DK1, S_DK2, S_CPY, S_CV, S_CR, S_FIN
    } state_t;

    // Row address of an edge entry: vertex row times degree plus position.
    function automatic logic [AW-1:0] eaddr(input logic [VW-1:0] v, input logic [DW-1:0] i);
        return AW'(v) * AW'(MAX_DEGREE) + AW'(i);
    endfunction

    // Physical position of logical entry r in a circular list that starts at h.
    function automatic logic [DW-1:0] phys(input logic [DW-1:0] h, input logic [DW-1:0] r);
        logic [DW:0] s;
        s = {1'b0, h} + {1'b0, r};
        if (s >= (DW+1)'(MAX_DEGREE))
        begin
            s = s - (DW+1)'(MAX_DEGREE);
        end
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] hdec(input logic [DW-1:0] h);
        return (h == '0) ? DW'(MAX_DEGREE - 1) : h - 1'b1;
    endfunction

    state_t state_reg, state_next;

    logic [ACT_W-1:0] act_reg, act_next;
    logic [3:0]       a_reg, a_next;
    logic [3:0]       b_reg, b_next;
    logic [15:0]      wt_reg, wt_next;
    logic [7:0]       key_reg, key_next;
    logic [3:0]       pos_reg, pos_next;

    logic [LNW-1:0] len_reg  [MAX_VERTICES];
    logic [LNW-1:0] len_next [MAX_VERTICES];
    logic [DW-1:0]  head_reg  [MAX_VERTICES];
    logic [DW-1:0]  head_next [MAX_VERTICES];
    logic [LW-1:0]  live_reg, live_next;
    logic [EW-1:0]  edges_reg, edges_next;

    logic [VW-1:0]  last_reg, last_next;
    logic [LW-1:0]  v_reg, v_next;
    logic [LNW-1:0] r_reg, r_next;
    logic [LNW-1:0] w_reg, w_next;
    logic [LNW-1:0] c_reg, c_next;

    logic [STAT_W-1:0] rst_reg, rst_next;     // result status
    logic              rfound_reg, rfound_next;
    logic [3:0]        rnb_reg, rnb_next;
    logic [15:0]       rwt_reg, rwt_next;
    logic [7:0]        rkey_reg, rkey_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]       m_tuser_reg, m_tuser_next;

    // RAM ports
    logic           key_we;
    logic [VW-1:0]  key_waddr, key_raddr;
    logic [7:0]     key_wdata, key_rdata;
    logic           edge_we;
    logic [AW-1:0]  edge_waddr, edge_raddr;
    logic [EWD-1:0] edge_wdata, edge_rdata;

    logic [VW-1:0] slot;
    logic          a_ok, b_ok;
    logic [VW-1:0] rd_nb;

    assign slot  = VW'(a_reg);
    assign a_ok  = int'(a_reg) < int'(live_reg);
    assign b_ok  = int'(b_reg) < int'(live_reg);
    assign rd_nb = edge_rdata[EWD-1:16];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    algs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(8)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    algs_ram #(.DEPTH(ED), .WIDTH(EWD)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    always_comb
    begin
        logic [DW-1:0]  h;
        logic [DW-1:0]  p;
        logic [VW-1:0]  vi;
        logic [LNW-1:0] wn;

        h  = '0;
        p  = '0;
        vi = VW'(v_reg);
        wn = w_reg;

        state_next  = state_reg;
        act_next    = act_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        wt_next     = wt_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        head_next   = head_reg;
        live_next   = live_reg;
        edges_next  = edges_reg;
        last_next   = last_reg;
        v_next      = v_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        c_next      = c_reg;
        rst_next    = rst_reg;
        rfound_next = rfound_reg;
        rnb_next    = rnb_reg;
        rwt_next    = rwt_reg;
        rkey_next   = rkey_reg;

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        key_we     = 1'b0;
        key_waddr  = slot;
        key_wdata  = key_rdata;
        key_raddr  = slot;
        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = edge_rdata;
        edge_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Capture the beat and clear the result fields.
                if (s_tvalid)
                begin
                    act_next    = s_tuser;
                    a_next      = s_tdata[3:0];
                    b_next      = s_tdata[7:4];
                    wt_next     = s_tdata[23:8];
                    key_next    = s_tdata[31:24];
                    pos_next    = s_tdata[35:32];
                    rst_next    = ST_OK;
                    rfound_next = 1'b0;
                    rnb_next    = '0;
                    rwt_next    = '0;
                    rkey_next   = '0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FIN;
                case (act_reg)
                    ACT_ADD_V:
                    begin
                        if (int'(live_reg) >= MAX_VERTICES)
                        begin
                            rst_next = ST_VFULL;
                        end
                        else
                        begin
                            key_we    = 1'b1;
                            key_waddr = VW'(live_reg);
                            key_wdata = key_reg;
                            len_next[VW'(live_reg)] = '0;
                            live_next = live_reg + 1'b1;
                        end
                    end
                    ACT_ADD_E:
                    begin
                        if (!a_ok || !b_ok)
                        begin
                            rst_next = ST_BADV;
                        end
                        else if (int'(len_reg[slot]) >= MAX_DEGREE)
                        begin
                            rst_next = ST_LFULL;
                        end
                        else
                        begin
                            // Prepend: step the head back one place and write there.
                            h          = hdec(head_reg[slot]);
                            edge_we    = 1'b1;
                            edge_waddr = eaddr(slot, h);
                            edge_wdata = {VW'(b_reg), wt_reg};
                            head_next[slot] = h;
                            len_next[slot]  = len_reg[slot] + 1'b1;
                            edges_next      = edges_reg + 1'b1;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (!a_ok || !b_ok)
                        begin
                            rst_next = ST_BADV;
                        end
                        else if (len_reg[slot] != '0)
                        begin
                            edge_raddr = eaddr(slot, head_reg[slot]);
                            r_next     = '0;
                            state_next = S_QRD;
                        end
                    end
                    ACT_FIRST, ACT_READ:
                    begin
                        p = (act_reg == ACT_FIRST) ? '0 : DW'(pos_reg);
                        if (!a_ok)
                        begin
                            rst_next = ST_BADV;
                        end
                        else if (act_reg == ACT_READ && int'(pos_reg) >= int'(len_reg[slot]))
                        begin
                            rst_next = ST_NOENT;
                        end
                        else if (len_reg[slot] == '0)
                        begin
                            rst_next = ST_NOENT;
                        end
                        else
                        begin
                            edge_raddr = eaddr(slot, phys(head_reg[slot], p));
                            state_next = S_RDE;
                        end
                    end
                    ACT_DEL:
                    begin
                        if (!a_ok)
                        begin
                            rst_next = ST_BADV;
                        end
                        else
                        begin
                            key_raddr  = slot;
                            last_next  = VW'(live_reg - 1'b1);
                            state_next = S_DK1;
                        end
                    end
                    default:
                    begin
                        rst_next = ST_OK;
                    end
                endcase
            end

            S_QRD:
            begin
                // Check the returned entry and fetch the next one.
                if (rd_nb == VW'(b_reg))
                begin
                    rfound_next = 1'b1;
                end
                if (r_reg + 1'b1 < len_reg[slot])
                begin
                    r_next     = r_reg + 1'b1;
                    edge_raddr = eaddr(slot, phys(head_reg[slot], DW'(r_reg + 1'b1)));
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_RDE:
            begin
                rnb_next   = 4'(rd_nb);
                rwt_next   = edge_rdata[15:0];
                state_next = S_FIN;
            end

            S_DK1:
            begin
                rkey_next  = key_rdata;
                key_raddr  = last_reg;
                state_next = S_DK2;
            end

            S_DK2:
            begin
                // Move the last vertex into the freed slot.
                key_we     = 1'b1;
                key_waddr  = slot;
                key_wdata  = key_rdata;
                live_next  = live_reg - 1'b1;
                edges_next = '0;
                v_next     = '0;
                if (slot != last_reg)
                begin
                    len_next[slot]  = len_reg[last_reg];
                    head_next[slot] = head_reg[last_reg];
                    c_next          = '0;
                    edge_raddr      = eaddr(last_reg, '0);
                    state_next      = S_CPY;
                end
                else
                begin
                    state_next = S_CV;
                end
                len_next[last_reg] = '0;
            end

            S_CPY:
            begin
                edge_we    = 1'b1;
                edge_waddr = eaddr(slot, DW'(c_reg));
                edge_wdata = edge_rdata;
                if (int'(c_reg) + 1 < MAX_DEGREE)
                begin
                    c_next     = c_reg + 1'b1;
                    edge_raddr = eaddr(last_reg, DW'(c_reg + 1'b1));
                end
                else
                begin
                    state_next = S_CV;
                end
            end

            S_CV:
            begin
                if (int'(v_reg) >= int'(live_reg))
                begin
                    state_next = S_FIN;
                end
                else if (len_reg[vi] == '0)
                begin
                    v_next = v_reg + 1'b1;
                end
                else
                begin
                    edge_raddr = eaddr(vi, head_reg[vi]);
                    r_next     = '0;
                    w_next     = '0;
                    state_next = S_CR;
                end
            end

            S_CR:
            begin
                // Drop edges to the freed slot, rename the old last vertex, compact.
                wn = w_reg;
                if (rd_nb != slot)
                begin
                    edge_we    = 1'b1;
                    edge_waddr = eaddr(vi, phys(head_reg[vi], DW'(w_reg)));
                    edge_wdata = {(rd_nb == last_reg) ? slot : rd_nb, edge_rdata[15:0]};
                    wn         = w_reg + 1'b1;
                end
                w_next = wn;
                if (r_reg + 1'b1 < len_reg[vi])
                begin
                    r_next     = r_reg + 1'b1;
                    edge_raddr = eaddr(vi, phys(head_reg[vi], DW'(r_reg + 1'b1)));
                end
                else
                begin
                    len_next[vi] = wn;
                    edges_next   = edges_reg + EW'(wn);
                    v_next       = v_reg + 1'b1;
                    state_next   = S_CV;
                end
            end

            S_FIN:
            begin
                // Hold until the output register is free, then load the result.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = rst_reg;
                    m_tdata_next  = {5'b0, 9'(edges_reg), 5'(live_reg), rkey_reg,
                                     rwt_reg, rnb_reg, rfound_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            live_reg     <= '0;
            edges_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                len_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            edges_reg    <= edges_next;
            m_tvalid_reg <= m_tvalid_next;
            len_reg      <= len_next;
            head_reg     <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        wt_reg      <= wt_next;
        key_reg     <= key_next;
        pos_reg     <= pos_next;
        last_reg    <= last_next;
        v_reg       <= v_next;
        r_reg       <= r_next;
        w_reg       <= w_next;
        c_reg       <= c_next;
        rst_reg     <= rst_next;
        rfound_reg  <= rfound_next;
        rnb_reg     <= rnb_next;
        rwt_reg     <= rwt_next;
        rkey_reg    <= rkey_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
